/* src/i2c_byte_master_defines.svh */
// Assertion macros used by the I2C byte master top level.
`ifndef I2C_BYTE_MASTER_DEFINES_SVH
`define I2C_BYTE_MASTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2C_BM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2C_BM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/i2c_bm_pkg.sv */
// Shared types, codes and defaults of the I2C byte master.
package i2c_bm_pkg;

  localparam int BYTE_BITS          = 8;
  localparam int COUNTER_WIDTH_DEF  = 16;
  localparam int CFG_WIDTH          = 16;
  localparam int CFG_IDX_WIDTH      = 2;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
  localparam logic [15:0] SETUP_TICKS_RST = 16'd10;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd10;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_PHASE_TICKS = 2'd0,
    REG_SETUP_TICKS = 2'd1,
    REG_POLL_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_WACK  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [2:0]           command;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 ack_level;
    logic                 sda_in;
  } i2c_bm_item_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] setup_ticks;
    logic [7:0]  ack_poll_limit;
  } i2c_bm_cfg_t;

  typedef struct packed {
    logic                 no_ack;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 done_res;
    logic                 busy_res;
    logic                 sda_release;
    logic                 scl_level;
  } i2c_bm_res_t;

endpackage

/* src/i2c_bm_seq.sv */
// Pin sequencer: one tick of the I2C command state machine per request.
module i2c_bm_seq #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  i2c_bm_pkg::i2c_bm_item_t item,
  input  i2c_bm_pkg::i2c_bm_cfg_t  cfg,
  output i2c_bm_pkg::i2c_bm_res_t  res
);
  import i2c_bm_pkg::*;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_ST_A, SQ_ST_B, SQ_ST_C, SQ_SP_A, SQ_SP_B, SQ_SP_C,
    SQ_WR_SET, SQ_WR_HI, SQ_WR_LO, SQ_RD_LO, SQ_RD_HI,
    SQ_AK_A, SQ_AK_B, SQ_AK_C, SQ_WA_LO, SQ_WA_HI, SQ_WA_POLL
  } seq_state_t;

  localparam logic [31:0] TICK_MAX = (32'd1 << COUNTER_WIDTH) - 32'd1;
  localparam logic [3:0]  LAST_BIT = 4'(BYTE_BITS);

  seq_state_t               step_r, step_nxt, ent_step;
  logic [COUNTER_WIDTH-1:0] tick_r, tick_nxt, tick_load;
  logic [3:0]               bit_r, bit_nxt;
  logic [BYTE_BITS-1:0]     shift_r, shift_nxt, rx_r, rx_nxt;
  logic [7:0]               polls_r, polls_nxt;
  logic                     scl_r, scl_nxt, sda_r, sda_nxt;
  logic                     ack_r, ack_nxt, ack_bit_r, ack_bit_nxt;
  logic                     ent, done;
  logic [15:0]              hold_ticks, hold_m1;
  logic [31:0]              hold_ext;

  // Hold length: ticks-1, zero acts as one tick, saturate at counter max.
  always_comb begin
    hold_m1   = (hold_ticks == 16'd0) ? 16'd0 : hold_ticks - 16'd1;
    hold_ext  = 32'(hold_m1);
    tick_load = (hold_ext > TICK_MAX) ? '1 : COUNTER_WIDTH'(hold_ext);
  end

  always_comb begin
    step_nxt    = step_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    polls_nxt   = polls_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    ack_bit_nxt = ack_bit_r;
    rx_nxt      = rx_r;
    ent         = 1'b0;
    ent_step    = SQ_IDLE;
    done        = 1'b0;
    hold_ticks  = cfg.phase_ticks;

    if (step_r == SQ_IDLE) begin
      bit_nxt = 4'd0;
      case (item.command)
        CMD_START: begin
          ent = 1'b1; ent_step = SQ_ST_A;
        end
        CMD_STOP: begin
          ent = 1'b1; ent_step = SQ_SP_A;
        end
        CMD_WRITE: begin
          shift_nxt = item.tx_byte; ent = 1'b1; ent_step = SQ_WR_SET;
        end
        CMD_READ: begin
          shift_nxt = '0; ent = 1'b1; ent_step = SQ_RD_LO;
        end
        CMD_ACK: begin
          ack_bit_nxt = item.ack_level; ent = 1'b1; ent_step = SQ_AK_A;
        end
        CMD_WACK: begin
          polls_nxt = cfg.ack_poll_limit; ent = 1'b1; ent_step = SQ_WA_LO;
        end
        default: ;
      endcase
    end else if (tick_r != '0) begin
      tick_nxt = tick_r - 1'b1;
    end else begin
      case (step_r)
        SQ_ST_A:   begin ent = 1'b1; ent_step = SQ_ST_B; end
        SQ_ST_B:   begin ent = 1'b1; ent_step = SQ_ST_C; end
        SQ_SP_A:   begin ent = 1'b1; ent_step = SQ_SP_B; end
        SQ_SP_B:   begin ent = 1'b1; ent_step = SQ_SP_C; end
        SQ_WR_SET: begin ent = 1'b1; ent_step = SQ_WR_HI; end
        SQ_WR_HI:  begin ent = 1'b1; ent_step = SQ_WR_LO; end
        SQ_WR_LO: begin
          shift_nxt = {shift_r[BYTE_BITS-2:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          if (bit_nxt >= LAST_BIT) begin
            done = 1'b1;
          end else begin
            ent = 1'b1; ent_step = SQ_WR_SET;
          end
        end
        SQ_RD_LO:  begin ent = 1'b1; ent_step = SQ_RD_HI; end
        SQ_RD_HI: begin
          shift_nxt = {shift_r[BYTE_BITS-2:0], item.sda_in};
          bit_nxt   = bit_r + 4'd1;
          if (bit_nxt >= LAST_BIT) begin
            scl_nxt = 1'b0;
            rx_nxt  = shift_nxt;
            done    = 1'b1;
          end else begin
            ent = 1'b1; ent_step = SQ_RD_LO;
          end
        end
        SQ_AK_A:   begin ent = 1'b1; ent_step = SQ_AK_B; end
        SQ_AK_B:   begin ent = 1'b1; ent_step = SQ_AK_C; end
        SQ_AK_C: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
        end
        SQ_WA_LO:  begin ent = 1'b1; ent_step = SQ_WA_HI; end
        SQ_WA_HI, SQ_WA_POLL: begin
          if (!item.sda_in) begin
            ack_nxt = 1'b0; scl_nxt = 1'b0; done = 1'b1;
          end else if (polls_r != 8'd0) begin
            polls_nxt = polls_r - 8'd1; ent = 1'b1; ent_step = SQ_WA_POLL;
          end else begin
            // No ack after all polls: flag it and release the bus with a stop.
            ack_nxt = 1'b1; ent = 1'b1; ent_step = SQ_SP_A;
          end
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      step_nxt = SQ_IDLE;
      tick_nxt = '0;
    end

    if (ent) begin
      step_nxt = ent_step;
      case (ent_step)
        SQ_ST_A:   begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        SQ_ST_B:   sda_nxt = 1'b0;
        SQ_ST_C:   scl_nxt = 1'b0;
        SQ_SP_A:   begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        SQ_SP_B:   scl_nxt = 1'b1;
        SQ_SP_C:   sda_nxt = 1'b1;
        SQ_WR_SET: begin
          scl_nxt    = 1'b0;
          sda_nxt    = shift_nxt[BYTE_BITS-1];
          hold_ticks = cfg.setup_ticks;
        end
        SQ_WR_HI:  scl_nxt = 1'b1;
        SQ_WR_LO:  scl_nxt = 1'b0;
        SQ_RD_LO:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        SQ_RD_HI:  scl_nxt = 1'b1;
        SQ_AK_A:   begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        SQ_AK_B:   sda_nxt = ack_bit_nxt;
        SQ_AK_C:   scl_nxt = 1'b1;
        SQ_WA_LO:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        SQ_WA_HI:  scl_nxt = 1'b1;
        default: ;
      endcase
      tick_nxt = tick_load;
    end

    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = (step_nxt != SQ_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_nxt;
    res.no_ack      = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= SQ_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      polls_r   <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      ack_r     <= 1'b0;
      ack_bit_r <= 1'b1;
      rx_r      <= '0;
    end else if (step_en) begin
      step_r    <= step_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      polls_r   <= polls_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_r     <= ack_nxt;
      ack_bit_r <= ack_bit_nxt;
      rx_r      <= rx_nxt;
    end
  end

endmodule

/* src/i2c_byte_master.sv */
// Top level of the tick-driven I2C byte master: ports, stages, config registers.
// A request accepted into the input register passes the sequencer logic into the result register, then shows on out_*.
// Throughput: one request per cycle through input register, sequencer logic, result register, while out_tready is high.
// A stalled output holds the result stage and, once the input stage is full, drops in_tready until out_tready returns.
// Reset (rst_n low at a clock edge, synchronous) empties both stages and restores
// the register defaults; the bus is released and the sequencer goes idle.
`include "i2c_byte_master_defines.svh"

module i2c_byte_master #(
  parameter int COUNTER_WIDTH = i2c_bm_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [i2c_bm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [i2c_bm_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  // Tick request stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [15:0]                          in_tdata,  // tx_byte[7:0], ack_level[8],
                                                          // sda_in[9], zero fill[15:10]
  input  logic [2:0]                           in_tuser,  // command[2:0]
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata  // scl_level[0], sda_release[1],
                                                          // busy_res[2], done_res[3],
                                                          // rx_byte[11:4], no_ack[12],
                                                          // zero fill[15:13]
);
  import i2c_bm_pkg::*;

  i2c_bm_cfg_t  cfg_r;
  i2c_bm_item_t s1_item_r;
  logic         s1_valid_r;
  i2c_bm_res_t  seq_res, out_res_r;
  logic         out_valid_r;
  logic         adv;

  // Move the held request into the sequencer when the result slot is free.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  // Config registers; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks    <= PHASE_TICKS_RST;
      cfg_r.setup_ticks    <= SETUP_TICKS_RST;
      cfg_r.ack_poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_TICKS: cfg_r.phase_ticks    <= cfg_wdata;
        REG_SETUP_TICKS: cfg_r.setup_ticks    <= cfg_wdata;
        REG_POLL_LIMIT:  cfg_r.ack_poll_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input stage: hold one request until the sequencer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.command   <= in_tuser;
      s1_item_r.tx_byte   <= in_tdata[7:0];
      s1_item_r.ack_level <= in_tdata[8];
      s1_item_r.sda_in    <= in_tdata[9];
    end
  end

  i2c_bm_seq #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (seq_res)
  );

  // Result stage: load on advance, drop once taken downstream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  // A finishing tick never reports the command as still running.
  `I2C_BM_ASSERT_NOW(a_done_not_busy, out_valid_r && out_res_r.done_res, !out_res_r.busy_res, "done with busy set")
  // Every advanced request lands in the result stage.
  `I2C_BM_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced request lost")
  // A held request stays put until the sequencer takes it.
  `I2C_BM_ASSERT_NEXT(a_s1_hold, s1_valid_r && !adv, s1_valid_r && $stable(s1_item_r), "input stage changed while held")

endmodule
